// ----- hw/rtl/lqsw_pkg.sv -----
// Shared constants for the link quality statistics window block.
// Metric slots, event codes, status codes and register indexes.
// No dependencies.
package lqsw_pkg;

   localparam int NUM_METRICS = 18;
   localparam int MIDX_W      = 5;
   localparam int CNT_W       = 53;
   localparam int EPOCH_W     = 63;
   localparam int CAP_W       = 20;

   localparam logic [CNT_W-1:0] COUNT_LIMIT = 53'h1F_FFFF_FFFF_FFFF;
   localparam logic [CAP_W-1:0] CAP_MAX     = 20'd1000000;

   // metric slots
   localparam logic [MIDX_W-1:0] M_ATT     = 5'd0;
   localparam logic [MIDX_W-1:0] M_RETRY   = 5'd1;
   localparam logic [MIDX_W-1:0] M_REPLAY  = 5'd2;
   localparam logic [MIDX_W-1:0] M_ACK     = 5'd3;
   localparam logic [MIDX_W-1:0] M_LAT_SUM = 5'd8;
   localparam logic [MIDX_W-1:0] M_LAT_MAX = 5'd9;
   localparam logic [MIDX_W-1:0] M_BSAMP   = 5'd10;
   localparam logic [MIDX_W-1:0] M_DSUM    = 5'd11;
   localparam logic [MIDX_W-1:0] M_DMAX    = 5'd12;
   localparam logic [MIDX_W-1:0] M_DLAST   = 5'd13;
   localparam logic [MIDX_W-1:0] M_CAP     = 5'd14;
   localparam logic [MIDX_W-1:0] M_DROP    = 5'd15;
   localparam logic [MIDX_W-1:0] M_LSAMP   = 5'd16;
   localparam logic [MIDX_W-1:0] M_OFF     = 5'd17;
   localparam logic [MIDX_W-1:0] M_LAST    = 5'd17;

   // event codes
   localparam logic [1:0] FUNC_ATTEMPT = 2'd0;
   localparam logic [1:0] FUNC_BUFFER  = 2'd1;
   localparam logic [1:0] FUNC_LINK    = 2'd2;
   localparam logic [1:0] FUNC_FREEZE  = 2'd3;

   localparam logic [2:0] OUT_ACK     = 3'd0;
   localparam logic [2:0] OUT_REJECT  = 3'd4;

   // freeze status
   localparam logic [1:0] ST_EMITTED  = 2'd0;
   localparam logic [1:0] ST_NOT_RDY  = 2'd1;
   localparam logic [1:0] ST_NO_BUF   = 2'd2;
   localparam logic [1:0] ST_TIME_OVF = 2'd3;

   // register indexes
   localparam logic [2:0] REG_ENABLE   = 3'd0;
   localparam logic [2:0] REG_CAPACITY = 3'd1;
   localparam logic [2:0] REG_INTERVAL = 3'd2;
   localparam logic [2:0] REG_BOOT_UP  = 3'd3;
   localparam logic [2:0] REG_BOOT_EP  = 3'd4;
   localparam logic [2:0] REG_INIT_DRP = 3'd5;

endpackage

// ----- hw/rtl/link_quality_stats_window.sv -----
// An event reads and writes back each counter it touches in turn (S_OPRD, S_OPWR);
// a freeze checks readiness (S_FCHK, S_FDEC), then reads and emits one metric beat per slot.
// Items are taken one at a time; counters live in an 18-entry memory with one
// read-modify-write per touched counter.
// Reset: synchronous; collector disabled, counters read as zero through per-entry
// valid bits, registers take their documented defaults. No clearing pass.
module link_quality_stats_window (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [31:0] sequence_number, [32] is_replay, [35:33] outcome, [88:36] elapsed_ms,
   // [108:89] buffer_depth, [172:109] drop_total, [173] link_up, [237:174] now_ms
   input  logic [239:0] req_tdata,
   // [1:0] func
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] window_number, [84:32] window_start_uptime, [137:85] window_end_uptime,
   // [200:138] window_start_epoch, [263:201] window_end_epoch,
   // [268:264] metric_index, [321:269] metric_value
   output logic [327:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]   rsp_tuser,
   // last_item
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_data
);

   localparam int NM = lqsw_pkg::NUM_METRICS;
   localparam int CW = lqsw_pkg::CNT_W;
   localparam int EW = lqsw_pkg::EPOCH_W;
   localparam int MW = lqsw_pkg::MIDX_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_OPRD = 3'd1;
   localparam logic [2:0] S_OPWR = 3'd2;
   localparam logic [2:0] S_FCHK = 3'd3;
   localparam logic [2:0] S_FDEC = 3'd4;
   localparam logic [2:0] S_FRD  = 3'd5;
   localparam logic [2:0] S_FOUT = 3'd6;

   // configuration registers
   logic          enable_ff;
   logic [19:0]   capacity_ff;
   logic [31:0]   interval_ff;
   logic [52:0]   boot_up_ff;
   logic [62:0]   boot_ep_ff;
   logic [63:0]   init_drop_ff;

   // collector state
   logic          ovf_ff, ovf_in;
   logic          seen_ff;
   logic [31:0]   prev_seq_ff;
   logic [63:0]   prev_drop_ff;
   logic [31:0]   win_ff;
   logic [52:0]   start_up_ff;
   logic [62:0]   start_ep_ff;
   logic [19:0]   cap_ff;
   logic [NM-1:0] valid_ff, valid_in;

   // sequencer
   logic [2:0]    state_ff, state_in;
   logic [NM-1:0] mask_ff, mask_in;
   logic [MW-1:0] cnt_ff, cnt_in;
   logic [52:0]   elapsed_ff;
   logic [19:0]   depth_ff;
   logic [63:0]   diff_ff;
   logic [63:0]   now_ff;

   // counter memory
   logic [CW-1:0] mem [NM];
   logic [CW-1:0] rd_data_ff;
   logic [MW-1:0] rd_addr_ff;
   logic          rd_en;
   logic [MW-1:0] rd_addr;
   logic          wr_en;
   logic [MW-1:0] wr_addr;
   logic [CW-1:0] wr_data;
   logic [CW-1:0] rd_val;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [327:0]  rsp_data_ff, rsp_data_in;
   logic [1:0]    rsp_user_ff, rsp_user_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          out_free;
   logic          load_out;

   // input fields
   logic [31:0]   in_seq;
   logic          in_replay;
   logic [2:0]    in_outcome;
   logic [52:0]   in_elapsed;
   logic [19:0]   in_depth;
   logic [63:0]   in_drop;
   logic          in_link;
   logic [63:0]   in_now;
   logic          req_fire;
   logic          csr_fire;
   logic          start;
   logic [NM-1:0] ev_mask;

   // op datapath
   logic [MW-1:0] op_idx;
   logic [63:0]   op_val;
   logic [64:0]   op_sum;

   // freeze datapath
   logic [31:0]   interval_eff;
   logic [63:0]   span64;
   logic [63:0]   end_ep64;
   logic          not_ready;
   logic          freeze_done;

   assign in_seq     = req_tdata[31:0];
   assign in_replay  = req_tdata[32];
   assign in_outcome = req_tdata[35:33];
   assign in_elapsed = req_tdata[88:36];
   assign in_depth   = req_tdata[108:89];
   assign in_drop    = req_tdata[172:109];
   assign in_link    = req_tdata[173];
   assign in_now     = req_tdata[237:174];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid;
   assign start      = csr_fire && (csr_index == lqsw_pkg::REG_ENABLE) && csr_data[0]
                       && !enable_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // lowest pending counter op
   always_comb begin
      op_idx = '0;
      for (int i = NM - 1; i >= 0; i--) begin
         if (mask_ff[i]) op_idx = MW'(i);
      end
   end

   // counters touched by the incoming event
   always_comb begin
      ev_mask = '0;
      if (enable_ff && !ovf_ff) begin
         case (req_tuser)
            lqsw_pkg::FUNC_ATTEMPT: begin
               if (in_outcome <= lqsw_pkg::OUT_REJECT) begin
                  ev_mask[lqsw_pkg::M_ATT] = 1'b1;
                  ev_mask[lqsw_pkg::M_RETRY] = seen_ff && (prev_seq_ff == in_seq);
                  ev_mask[lqsw_pkg::M_REPLAY] = in_replay;
                  if (in_outcome == lqsw_pkg::OUT_ACK) begin
                     ev_mask[lqsw_pkg::M_ACK] = 1'b1;
                     ev_mask[lqsw_pkg::M_LAT_SUM] = 1'b1;
                     ev_mask[lqsw_pkg::M_LAT_MAX] = 1'b1;
                  end else begin
                     ev_mask[lqsw_pkg::M_ACK + MW'(in_outcome)] = 1'b1;
                  end
               end
            end
            lqsw_pkg::FUNC_BUFFER: begin
               if (in_depth <= cap_ff) begin
                  ev_mask[lqsw_pkg::M_BSAMP] = 1'b1;
                  ev_mask[lqsw_pkg::M_DSUM]  = 1'b1;
                  ev_mask[lqsw_pkg::M_DMAX]  = 1'b1;
                  ev_mask[lqsw_pkg::M_DLAST] = 1'b1;
                  ev_mask[lqsw_pkg::M_DROP]  = (in_drop >= prev_drop_ff);
               end
            end
            lqsw_pkg::FUNC_LINK: begin
               ev_mask[lqsw_pkg::M_LSAMP] = 1'b1;
               ev_mask[lqsw_pkg::M_OFF]   = !in_link;
            end
            default: ev_mask = '0;
         endcase
      end
   end

   // memory read value; capacity sits in its own register
   always_comb begin
      if (rd_addr_ff == lqsw_pkg::M_CAP) begin
         rd_val = CW'(cap_ff);
      end else if (valid_ff[rd_addr_ff]) begin
         rd_val = rd_data_ff;
      end else begin
         rd_val = '0;
      end
   end

   // operand of the current op
   always_comb begin
      case (op_idx)
         lqsw_pkg::M_LAT_SUM, lqsw_pkg::M_LAT_MAX: op_val = 64'(elapsed_ff);
         lqsw_pkg::M_DSUM, lqsw_pkg::M_DMAX, lqsw_pkg::M_DLAST: op_val = 64'(depth_ff);
         lqsw_pkg::M_DROP: op_val = diff_ff;
         default: op_val = 64'd1;
      endcase
   end
   assign op_sum = 65'(rd_val) + 65'(op_val);

   // freeze checks
   assign interval_eff = (interval_ff == 32'd0) ? 32'd1 : interval_ff;
   assign span64       = now_ff - 64'(start_up_ff);
   assign end_ep64     = 64'(start_ep_ff) + 64'(span64[52:0]);
   assign not_ready    = !enable_ff || ovf_ff || (win_ff == 32'd0)
                         || (now_ff > 64'(lqsw_pkg::COUNT_LIMIT))
                         || (now_ff < 64'(start_up_ff)) || (span64 < 64'(interval_eff));
   assign freeze_done  = (state_ff == S_FOUT) && out_free && (cnt_ff == lqsw_pkg::M_LAST);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      mask_in     = mask_ff;
      cnt_in      = cnt_ff;
      ovf_in      = ovf_ff;
      valid_in    = valid_ff;
      rd_en       = 1'b0;
      rd_addr     = op_idx;
      wr_en       = 1'b0;
      wr_addr     = op_idx;
      wr_data     = op_sum[CW-1:0];
      load_out    = 1'b0;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rsp_last_in = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_tuser == lqsw_pkg::FUNC_FREEZE) begin
                  state_in = S_FCHK;
               end else begin
                  mask_in  = ev_mask;
                  state_in = S_OPRD;
               end
            end
         end
         S_OPRD: begin
            if (mask_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               rd_en    = 1'b1;
               state_in = S_OPWR;
            end
         end
         S_OPWR: begin
            // modify and write back one counter
            case (op_idx)
               lqsw_pkg::M_LAT_MAX, lqsw_pkg::M_DMAX: begin
                  wr_data = op_val[CW-1:0];
                  wr_en   = (op_val > 64'(rd_val));
               end
               lqsw_pkg::M_DLAST: begin
                  wr_data = op_val[CW-1:0];
                  wr_en   = 1'b1;
               end
               default: begin
                  if (op_sum > 65'(lqsw_pkg::COUNT_LIMIT)) begin
                     ovf_in = 1'b1;
                  end else begin
                     wr_en = 1'b1;
                  end
               end
            endcase
            if (wr_en) valid_in[op_idx] = 1'b1;
            mask_in[op_idx] = 1'b0;
            state_in = S_OPRD;
         end
         S_FCHK: begin
            rd_en    = 1'b1;
            rd_addr  = lqsw_pkg::M_BSAMP;
            state_in = S_FDEC;
         end
         S_FDEC: begin
            if (not_ready || rd_val == '0 || end_ep64[63]) begin
               if (out_free) begin
                  load_out    = 1'b1;
                  rsp_data_in = '0;
                  rsp_last_in = 1'b1;
                  if (not_ready) begin
                     rsp_user_in = lqsw_pkg::ST_NOT_RDY;
                  end else if (rd_val == '0) begin
                     rsp_user_in = lqsw_pkg::ST_NO_BUF;
                  end else begin
                     rsp_user_in = lqsw_pkg::ST_TIME_OVF;
                  end
                  state_in = S_IDLE;
               end
            end else begin
               cnt_in   = '0;
               state_in = S_FRD;
            end
         end
         S_FRD: begin
            rd_en    = 1'b1;
            rd_addr  = cnt_ff;
            state_in = S_FOUT;
         end
         S_FOUT: begin
            // hold the read until the output register frees up
            if (out_free) begin
               load_out    = 1'b1;
               rsp_user_in = lqsw_pkg::ST_EMITTED;
               rsp_last_in = (cnt_ff == lqsw_pkg::M_LAST);
               rsp_data_in = {6'd0, rd_val, cnt_ff, end_ep64[EW-1:0], start_ep_ff,
                              now_ff[52:0], start_up_ff, win_ff};
               if (cnt_ff == lqsw_pkg::M_LAST) begin
                  valid_in = '0;
                  state_in = S_IDLE;
               end else begin
                  cnt_in   = cnt_ff + MW'(1);
                  state_in = S_FRD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // counter memory
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   // item payload, response fields and sequencer registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         elapsed_ff <= in_elapsed;
         depth_ff   <= in_depth;
         diff_ff    <= in_drop - prev_drop_ff;
         now_ff     <= in_now;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
      mask_ff     <= mask_in;
      cnt_ff      <= cnt_in;
   end

   // control and collector state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         enable_ff    <= 1'b0;
         capacity_ff  <= 20'd1;
         interval_ff  <= 32'd60000;
         boot_up_ff   <= '0;
         boot_ep_ff   <= 63'd1;
         init_drop_ff <= '0;
         ovf_ff       <= 1'b0;
         seen_ff      <= 1'b0;
         prev_seq_ff  <= '0;
         prev_drop_ff <= '0;
         win_ff       <= 32'd1;
         start_up_ff  <= '0;
         start_ep_ff  <= 63'd1;
         cap_ff       <= '0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         // register writes
         if (csr_fire) begin
            case (csr_index)
               lqsw_pkg::REG_ENABLE:   enable_ff    <= csr_data[0];
               lqsw_pkg::REG_CAPACITY: capacity_ff  <= csr_data[19:0];
               lqsw_pkg::REG_INTERVAL: interval_ff  <= csr_data[31:0];
               lqsw_pkg::REG_BOOT_UP:  boot_up_ff   <= csr_data[52:0];
               lqsw_pkg::REG_BOOT_EP:  boot_ep_ff   <= csr_data[62:0];
               lqsw_pkg::REG_INIT_DRP: init_drop_ff <= csr_data;
               default: ;
            endcase
         end
         if (start) begin
            // fresh collector on enable rising
            valid_ff     <= '0;
            ovf_ff       <= 1'b0;
            seen_ff      <= 1'b0;
            prev_seq_ff  <= '0;
            win_ff       <= 32'd1;
            start_up_ff  <= boot_up_ff;
            start_ep_ff  <= (boot_ep_ff == '0) ? 63'd1 : boot_ep_ff;
            prev_drop_ff <= init_drop_ff;
            if (capacity_ff == '0) begin
               cap_ff <= 20'd1;
            end else if (capacity_ff > lqsw_pkg::CAP_MAX) begin
               cap_ff <= lqsw_pkg::CAP_MAX;
            end else begin
               cap_ff <= capacity_ff;
            end
         end else begin
            ovf_ff   <= ovf_in;
            valid_ff <= valid_in;
            // remember the last attempt and drop total
            if (req_fire && enable_ff && !ovf_ff) begin
               if (req_tuser == lqsw_pkg::FUNC_ATTEMPT
                   && in_outcome <= lqsw_pkg::OUT_REJECT) begin
                  seen_ff     <= 1'b1;
                  prev_seq_ff <= in_seq;
               end
               if (req_tuser == lqsw_pkg::FUNC_BUFFER && in_depth <= cap_ff) begin
                  prev_drop_ff <= in_drop;
               end
            end
            // open the next window
            if (freeze_done) begin
               start_up_ff <= now_ff[52:0];
               start_ep_ff <= end_ep64[EW-1:0];
               win_ff      <= win_ff + 32'd1;
            end
         end
      end
   end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for the link quality statistics window block.
// Holds a scoreboard class that predicts every freeze result; depends on lqsw_pkg
// and the link_quality_stats_window RTL.
module tb_top;

   localparam logic [2:0] OUT_TRANSPORT = 3'd1;
   localparam logic [2:0] OUT_RETRYABLE = 3'd2;
   localparam logic [2:0] OUT_CFG_FAIL  = 3'd3;
   localparam logic [2:0] OUT_UNKNOWN   = 3'd5;
   localparam logic [2:0] OUT_INVALID   = 3'd7;
   localparam logic [2:0] REG_SPARE_LO  = 3'd6;
   localparam logic [2:0] REG_SPARE_HI  = 3'd7;
   localparam logic [63:0] LIMIT64 = 64'h001F_FFFF_FFFF_FFFF;
   localparam logic [63:0] MASK63  = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] seq;
      logic        replay;
      logic [2:0]  outcome;
      logic [52:0] elapsed;
      logic [19:0] depth;
      logic [63:0] drops;
      logic        link;
      logic [63:0] now;
   } event_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] win;
      logic [52:0] start_up;
      logic [52:0] end_up;
      logic [62:0] start_ep;
      logic [62:0] end_ep;
      logic [4:0]  midx;
      logic [52:0] mval;
      logic        last;
   } window_beat_type;

   // Window statistics predictor and store of expected freeze beats
   class window_scoreboard;
      logic        en;
      logic [19:0] cap_reg;
      logic [31:0] interval;
      logic [52:0] boot_up;
      logic [62:0] boot_ep;
      logic [63:0] init_drop;
      logic [63:0] counters [lqsw_pkg::NUM_METRICS];
      logic        ovf, seen;
      logic [31:0] prev_seq, win_cnt;
      logic [63:0] prev_drop, start_up, start_ep;
      window_beat_type expected_beats [$];
      int errors, beats_seen, windows_emitted, events_taken;

      function new();
         en = 0; cap_reg = 1; interval = 60000; boot_up = 0; boot_ep = 1; init_drop = 0;
         foreach (counters[i]) counters[i] = 0;
         ovf = 0; seen = 0; prev_seq = 0; win_cnt = 1;
         prev_drop = 0; start_up = 0; start_ep = 1;
         errors = 0; beats_seen = 0; windows_emitted = 0; events_taken = 0;
      endfunction

      function void bump(int idx, logic [63:0] v);
         if (v > LIMIT64 - counters[idx]) ovf = 1;
         else counters[idx] += v;
      endfunction

      function void write_reg(logic [2:0] idx, logic [63:0] data);
         logic [63:0] cap;
         case (idx)
            lqsw_pkg::REG_ENABLE: begin
               if (data[0] && !en) begin
                  cap = 64'(cap_reg);
                  if (cap < 1) cap = 1;
                  if (cap > 64'(lqsw_pkg::CAP_MAX)) cap = 64'(lqsw_pkg::CAP_MAX);
                  foreach (counters[i]) counters[i] = 0;
                  counters[lqsw_pkg::M_CAP] = cap;
                  ovf = 0; seen = 0; prev_seq = 0; win_cnt = 1;
                  start_up = (64'(boot_up) > LIMIT64) ? LIMIT64 : 64'(boot_up);
                  start_ep = (boot_ep == 0) ? 64'd1 : 64'(boot_ep);
                  prev_drop = init_drop;
               end
               en = data[0];
            end
            lqsw_pkg::REG_CAPACITY: cap_reg = data[19:0];
            lqsw_pkg::REG_INTERVAL: interval = data[31:0];
            lqsw_pkg::REG_BOOT_UP:  boot_up = data[52:0];
            lqsw_pkg::REG_BOOT_EP:  boot_ep = data[62:0];
            lqsw_pkg::REG_INIT_DRP: init_drop = data;
            default: ;
         endcase
      endfunction

      function void push_status(logic [1:0] st);
         window_beat_type b;
         b = '0;
         b.status = st;
         b.last = 1;
         expected_beats.push_back(b);
      endfunction

      // Predict the beats caused by one accepted event
      function void note_item(event_type r);
         logic [63:0] ivl, span, end_ep, cap;
         window_beat_type b;
         events_taken++;
         if (r.func == lqsw_pkg::FUNC_FREEZE) begin
            ivl = (interval == 0) ? 64'd1 : 64'(interval);
            if (!en || ovf || win_cnt == 0 || r.now > LIMIT64 || r.now < start_up ||
                r.now - start_up < ivl) begin
               push_status(lqsw_pkg::ST_NOT_RDY);
               return;
            end
            if (counters[lqsw_pkg::M_BSAMP] == 0) begin
               push_status(lqsw_pkg::ST_NO_BUF);
               return;
            end
            span = r.now - start_up;
            if (span > MASK63 - start_ep) begin
               push_status(lqsw_pkg::ST_TIME_OVF);
               return;
            end
            end_ep = start_ep + span;
            for (int i = 0; i < lqsw_pkg::NUM_METRICS; i++) begin
               b.status = lqsw_pkg::ST_EMITTED;
               b.win = win_cnt;
               b.start_up = start_up[52:0];
               b.end_up = r.now[52:0];
               b.start_ep = start_ep[62:0];
               b.end_ep = end_ep[62:0];
               b.midx = 5'(i);
               b.mval = counters[i][52:0];
               b.last = (i == lqsw_pkg::NUM_METRICS - 1);
               expected_beats.push_back(b);
            end
            cap = counters[lqsw_pkg::M_CAP];
            foreach (counters[i]) counters[i] = 0;
            counters[lqsw_pkg::M_CAP] = cap;
            start_up = r.now;
            start_ep = end_ep;
            win_cnt++;
            windows_emitted++;
            return;
         end
         if (!en || ovf) return;
         case (r.func)
            lqsw_pkg::FUNC_ATTEMPT: begin
               if (r.outcome > lqsw_pkg::OUT_REJECT) return;
               bump(lqsw_pkg::M_ATT, 1);
               if (seen && prev_seq == r.seq) bump(lqsw_pkg::M_RETRY, 1);
               if (r.replay) bump(lqsw_pkg::M_REPLAY, 1);
               seen = 1;
               prev_seq = r.seq;
               if (r.outcome == lqsw_pkg::OUT_ACK) begin
                  bump(lqsw_pkg::M_ACK, 1);
                  bump(lqsw_pkg::M_LAT_SUM, 64'(r.elapsed));
                  if (64'(r.elapsed) > counters[lqsw_pkg::M_LAT_MAX])
                     counters[lqsw_pkg::M_LAT_MAX] = 64'(r.elapsed);
               end else begin
                  bump(lqsw_pkg::M_ACK + r.outcome, 1);
               end
            end
            lqsw_pkg::FUNC_BUFFER: begin
               if (64'(r.depth) > counters[lqsw_pkg::M_CAP]) return;
               bump(lqsw_pkg::M_BSAMP, 1);
               bump(lqsw_pkg::M_DSUM, 64'(r.depth));
               counters[lqsw_pkg::M_DLAST] = 64'(r.depth);
               if (64'(r.depth) > counters[lqsw_pkg::M_DMAX])
                  counters[lqsw_pkg::M_DMAX] = 64'(r.depth);
               if (r.drops >= prev_drop) bump(lqsw_pkg::M_DROP, r.drops - prev_drop);
               prev_drop = r.drops;
            end
            default: begin
               bump(lqsw_pkg::M_LSAMP, 1);
               if (!r.link) bump(lqsw_pkg::M_OFF, 1);
            end
         endcase
      endfunction

      function void cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
         if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
         end
      endfunction

      // Compare one received beat with the oldest expectation
      function void check_result(window_beat_type got);
         window_beat_type e;
         beats_seen++;
         if (expected_beats.size() == 0) begin
            $error("unexpected beat: status %0d metric %0d", got.status, got.midx);
            errors++;
            return;
         end
         e = expected_beats.pop_front();
         cmp("status", 64'(e.status), 64'(got.status));
         cmp("window_number", 64'(e.win), 64'(got.win));
         cmp("window_start_uptime", 64'(e.start_up), 64'(got.start_up));
         cmp("window_end_uptime", 64'(e.end_up), 64'(got.end_up));
         cmp("window_start_epoch", 64'(e.start_ep), 64'(got.start_ep));
         cmp("window_end_epoch", 64'(e.end_ep), 64'(got.end_ep));
         cmp("metric_index", 64'(e.midx), 64'(got.midx));
         cmp("metric_value", 64'(e.mval), 64'(got.mval));
         cmp("last_item", 64'(e.last), 64'(got.last));
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [239:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [327:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_valid = 0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   window_scoreboard sb = new();
   int long_hold = 0;
   int beat_gap = 0;
   bit no_idle = 0;

   link_quality_stats_window dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // Receiver: drop tready for the drawn gap or a long hold-off
   initial forever begin
      @(negedge clock);
      if (long_hold > 0) begin
         rsp_tready <= 0;
         long_hold--;
      end else if (beat_gap > 0) begin
         rsp_tready <= 0;
         beat_gap--;
      end else begin
         rsp_tready <= 1;
      end
   end

   // Monitor: check every accepted beat, then draw the next stall
   always @(posedge clock) begin
      window_beat_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tuser;
         got.win = rsp_tdata[31:0];
         got.start_up = rsp_tdata[84:32];
         got.end_up = rsp_tdata[137:85];
         got.start_ep = rsp_tdata[200:138];
         got.end_ep = rsp_tdata[263:201];
         got.midx = rsp_tdata[268:264];
         got.mval = rsp_tdata[321:269];
         got.last = rsp_tlast;
         sb.check_result(got);
         beat_gap = no_idle ? 0 : $urandom_range(0, 7);
      end
   end

   initial begin
      #2_000_000;
      $display("link_quality_stats_window: mismatch");
      $finish;
   end

   function automatic event_type mk(logic [1:0] f, logic [31:0] s, logic rp, logic [2:0] o,
                                    logic [52:0] el, logic [19:0] d, logic [63:0] dr,
                                    logic lk, logic [63:0] n);
      event_type r;
      r.func = f; r.seq = s; r.replay = rp; r.outcome = o; r.elapsed = el;
      r.depth = d; r.drops = dr; r.link = lk; r.now = n;
      return r;
   endfunction

   // Offer one event after a random gap; return at the falling edge after it is accepted
   task automatic send_event(event_type r);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= r.func;
      req_tdata <= {2'b00, r.now, r.link, r.drops, r.depth, r.elapsed, r.outcome,
                    r.replay, r.seq};
      do @(posedge clock); while (!req_tready);
      sb.note_item(r);
      @(negedge clock);
   endtask

   // Hold the input until every expected beat is out and the block is quiet
   task automatic drain();
      req_tvalid <= 0;
      while (sb.expected_beats.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [63:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   task automatic restart(logic [63:0] cap, logic [63:0] ivl, logic [63:0] up,
                          logic [63:0] ep, logic [63:0] drp);
      csr_write(lqsw_pkg::REG_ENABLE, 0);
      csr_write(lqsw_pkg::REG_CAPACITY, cap);
      csr_write(lqsw_pkg::REG_INTERVAL, ivl);
      csr_write(lqsw_pkg::REG_BOOT_UP, up);
      csr_write(lqsw_pkg::REG_BOOT_EP, ep);
      csr_write(lqsw_pkg::REG_INIT_DRP, drp);
      csr_write(lqsw_pkg::REG_ENABLE, 1);
   endtask

   // Random event, mostly well-formed windows with random content
   function automatic event_type rand_event();
      event_type r;
      int pick, k;
      logic [63:0] ivl;
      r = mk(2'($urandom_range(0, 2)), $urandom_range(0, 3), 1'($urandom_range(0, 1)),
             3'($urandom_range(0, 7)), 53'($urandom_range(0, 500)), '0, '0,
             1'($urandom_range(0, 1)), '0);
      r.depth = ($urandom_range(0, 3) == 0) ? 20'($urandom) :
                20'($urandom_range(0, sb.counters[lqsw_pkg::M_CAP] + 2));
      k = $urandom_range(0, 9);
      r.drops = (k == 0) ? {$urandom, $urandom} :
                (k == 1) ? sb.prev_drop - 3 : sb.prev_drop + $urandom_range(0, 40);
      if ($urandom_range(0, 9) == 0) r.seq = $urandom;
      if ($urandom_range(0, 9) == 0) r.elapsed = 53'({$urandom, $urandom});
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
         r.func = lqsw_pkg::FUNC_FREEZE;
         ivl = (sb.interval == 0) ? 64'd1 : 64'(sb.interval);
         k = $urandom_range(0, 9);
         r.now = (k == 0) ? {$urandom, $urandom} :
                 (k == 1) ? sb.start_up + ivl - 1 : sb.start_up + ivl + $urandom_range(0, 30);
      end
      return r;
   endfunction

   initial begin
      event_type r;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // disabled collector: events ignored, freeze not ready
      send_event(mk(lqsw_pkg::FUNC_ATTEMPT, 7, 1, lqsw_pkg::OUT_ACK, 5, 0, 0, 0, 0));
      send_event(mk(lqsw_pkg::FUNC_BUFFER, 0, 0, 0, 0, 0, 9, 0, 0));
      send_event(mk(lqsw_pkg::FUNC_FREEZE, 0, 0, 0, 0, 0, 0, 0, 70000));
      drain();

      // directed window: every counted outcome, two rejected codes, retries, replays, deep and shallow samples
      restart(64'(lqsw_pkg::CAP_MAX), 10, 100, 1, 5);
      csr_write(REG_SPARE_LO, 64'hFFFF);
      csr_write(REG_SPARE_HI, 1);
      send_event(mk(lqsw_pkg::FUNC_FREEZE, 0, 0, 0, 0, 0, 0, 0, 50));
      send_event(mk(lqsw_pkg::FUNC_FREEZE, 0, 0, 0, 0, 0, 0, 0, 200));
      send_event(mk(lqsw_pkg::FUNC_ATTEMPT, 32'hFFFF_FFFF, 1, lqsw_pkg::OUT_ACK,
                    53'h1F_FFFF_FFFF, 0, 0, 0, 0));
      send_event(mk(lqsw_pkg::FUNC_ATTEMPT, 32'hFFFF_FFFF, 0, OUT_TRANSPORT, 0, 0, 0, 0, 0));
      send_event(mk(lqsw_pkg::FUNC_ATTEMPT, 0, 1, OUT_RETRYABLE, 0, 0, 0, 0, 0));
      send_event(mk(lqsw_pkg::FUNC_ATTEMPT, 0, 0, OUT_CFG_FAIL, 0, 0, 0, 0, 0));
      send_event(mk(lqsw_pkg::FUNC_ATTEMPT, 1, 0, lqsw_pkg::OUT_REJECT, 0, 0, 0, 0, 0));
      send_event(mk(lqsw_pkg::FUNC_ATTEMPT, 1, 1, OUT_UNKNOWN, 0, 0, 0, 0, 0));
      send_event(mk(lqsw_pkg::FUNC_ATTEMPT, 1, 1, OUT_INVALID, 0, 0, 0, 0, 0));
      send_event(mk(lqsw_pkg::FUNC_BUFFER, 0, 0, 0, 0, lqsw_pkg::CAP_MAX,
                    64'hFFFF_FFFF_FFFF_FFFF, 0, 0));
      send_event(mk(lqsw_pkg::FUNC_BUFFER, 0, 0, 0, 0, 20'hFFFFF, 3, 0, 0));
      send_event(mk(lqsw_pkg::FUNC_BUFFER, 0, 0, 0, 0, 0, 2, 0, 0));
      send_event(mk(lqsw_pkg::FUNC_BUFFER, 0, 0, 0, 0, 17, 10, 0, 0));
      send_event(mk(lqsw_pkg::FUNC_LINK, 0, 0, 0, 0, 0, 0, 1, 0));
      send_event(mk(lqsw_pkg::FUNC_LINK, 0, 0, 0, 0, 0, 0, 0, 0));
      send_event(mk(lqsw_pkg::FUNC_FREEZE, 0, 0, 0, 0, 0, 0, 0, 109));
      send_event(mk(lqsw_pkg::FUNC_FREEZE, 0, 0, 0, 0, 0, 0, 0, 110));
      send_event(mk(lqsw_pkg::FUNC_FREEZE, 0, 0, 0, 0, 0, 0, 0, 64'h8000_0000_0000_0000));
      send_event(mk(lqsw_pkg::FUNC_FREEZE, 0, 0, 0, 0, 0, 0, 0, 200));
      // overflow of the latency sum stops counting and freezing
      send_event(mk(lqsw_pkg::FUNC_ATTEMPT, 5, 0, lqsw_pkg::OUT_ACK, 53'h1F_FFFF_FFFF_FFFF,
                    0, 0, 0, 0));
      send_event(mk(lqsw_pkg::FUNC_ATTEMPT, 6, 0, lqsw_pkg::OUT_ACK, 1, 0, 0, 0, 0));
      send_event(mk(lqsw_pkg::FUNC_BUFFER, 0, 0, 0, 0, 1, 0, 0, 0));
      send_event(mk(lqsw_pkg::FUNC_FREEZE, 0, 0, 0, 0, 0, 0, 0, 500));
      drain();

      // extreme settings: saturated capacity, zero interval, epoch at the top
      csr_write(lqsw_pkg::REG_ENABLE, 1);
      restart(64'hFFFF_FFFF_FFFF_FFFF, 0, 64'h001F_FFFF_FFFF_FFF0,
              64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_event(mk(lqsw_pkg::FUNC_BUFFER, 0, 0, 0, 0, 5, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0));
      send_event(mk(lqsw_pkg::FUNC_FREEZE, 0, 0, 0, 0, 0, 0, 0, LIMIT64));
      drain();
      restart(0, 64'hFFFF_FFFF, 7, 0, 0);
      send_event(mk(lqsw_pkg::FUNC_BUFFER, 0, 0, 0, 0, 1, 0, 0, 0));
      send_event(mk(lqsw_pkg::FUNC_FREEZE, 0, 0, 0, 0, 0, 0, 0, 64'h1_0000_0006));
      drain();

      // random windows under two settings, with a long receiver hold and a pause
      restart(64'($urandom_range(1, 300)), 64'($urandom_range(1, 40)), {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom});
      for (int i = 0; i < 200; i++) begin
         if (i == 40) long_hold = 400;
         if (i == 90) begin
            drain();
            restart(64'($urandom_range(1, 2000)), 64'($urandom_range(0, 20)),
                    64'($urandom_range(0, 1000)), {1'b0, 31'($urandom), $urandom},
                    {$urandom, $urandom});
         end
         if (i == 130) begin
            req_tvalid <= 0;
            do @(negedge clock); while (sb.expected_beats.size() != 0);
         end
         no_idle = (i >= 150 && i < 175);
         r = rand_event();
         send_event(r);
      end
      no_idle = 0;
      drain();
      repeat (40) @(posedge clock);

      $display("Run covered %0d events, %0d result beats, %0d emitted windows.",
               sb.events_taken, sb.beats_seen, sb.windows_emitted);
      if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
         $display("link_quality_stats_window: match");
      end else begin
         if (sb.expected_beats.size() != 0)
            $error("%0d expected beats never arrived", sb.expected_beats.size());
         $display("link_quality_stats_window: mismatch");
      end
      $finish;
   end
endmodule

// ----- sim.f -----
hw/rtl/lqsw_pkg.sv
hw/rtl/link_quality_stats_window.sv
tb/tb_top.sv
